// ===== sv/window_coefficient_apply_macros.svh =====
// Assertion macros shared by the window weighting RTL.
`ifndef WINDOW_COEFFICIENT_APPLY_MACROS_SVH
`define WINDOW_COEFFICIENT_APPLY_MACROS_SVH

// Same-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define WCA_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define WCA_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/wca_pkg.sv =====
// Shared types, register codes and coefficient tables of the window weighting block.
package wca_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned WTYPE_W    = 4;
  localparam int unsigned FLEN_W     = 13;
  localparam int unsigned COS_W      = 18;
  localparam int unsigned COEF_W     = 27;
  localparam int unsigned MUL_W      = 33;
  localparam int unsigned ACC_W      = 48;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_TYPE  = 2'd0,
    REG_FRAME_LENGTH = 2'd1,
    REG_RECIP_SPAN   = 2'd2,
    REG_RECIP_LEN    = 2'd3
  } cfg_reg_e;

  // Window type codes.
  typedef enum logic [WTYPE_W-1:0] {
    WIN_HANN       = 4'd0,
    WIN_HANN_AC    = 4'd1,
    WIN_HAMMING    = 4'd2,
    WIN_BLACKMAN   = 4'd3,
    WIN_BLACK_HARR = 4'd4,
    WIN_BARTLETT   = 4'd5,
    WIN_BART_HANN  = 4'd6,
    WIN_CONNES     = 4'd7,
    WIN_FLATTOP    = 4'd8,
    WIN_KB_APPROX  = 4'd9,
    WIN_NUTTALL    = 4'd10,
    WIN_WELCH      = 4'd11
  } win_type_e;

  // How a window type is evaluated.
  typedef enum logic [2:0] {
    CLS_COSSUM,
    CLS_HANN_AC,
    CLS_BHANN,
    CLS_BART,
    CLS_CONNES,
    CLS_WELCH,
    CLS_UNITY
  } win_class_e;

  typedef logic signed [COEF_W-1:0] coef_row_t [0:4];

  function automatic win_class_e win_class(logic [WTYPE_W-1:0] t);
    win_class_e c;
    case (t) inside
      WIN_HANN, WIN_HAMMING, WIN_BLACKMAN, WIN_BLACK_HARR,
      WIN_FLATTOP, WIN_KB_APPROX, WIN_NUTTALL: c = CLS_COSSUM;
      WIN_HANN_AC:   c = CLS_HANN_AC;
      WIN_BART_HANN: c = CLS_BHANN;
      WIN_BARTLETT:  c = CLS_BART;
      WIN_CONNES:    c = CLS_CONNES;
      WIN_WELCH:     c = CLS_WELCH;
      default:       c = CLS_UNITY;
    endcase
    return c;
  endfunction

  // Q24 coefficients: constant term, then the terms of cos(2 pi m x), m = 1 .. 4.
  // Amplitude complementary hann and bartlett-hann keep only their cosine term here.
  function automatic coef_row_t coef_row(logic [WTYPE_W-1:0] t);
    coef_row_t r;
    case (t)
      WIN_HANN:       r = '{27'sd8388608, -27'sd8388608, 27'sd0, 27'sd0, 27'sd0};
      WIN_HANN_AC:    r = '{27'sd0, 27'sd8388608, 27'sd0, 27'sd0, 27'sd0};
      WIN_HAMMING:    r = '{27'sd9059697, -27'sd7717519, 27'sd0, 27'sd0, 27'sd0};
      WIN_BLACKMAN:   r = '{27'sd7046431, -27'sd8388608, 27'sd1342177, 27'sd0, 27'sd0};
      WIN_BLACK_HARR: r = '{27'sd6018826, -27'sd8192147, 27'sd2370285, -27'sd195958,
                            27'sd0};
      WIN_BART_HANN:  r = '{27'sd0, -27'sd6375342, 27'sd0, 27'sd0, 27'sd0};
      WIN_FLATTOP:    r = '{27'sd16777216, -27'sd32380027, 27'sd21642609,
                            -27'sd6509560, 27'sd540226};
      WIN_KB_APPROX:  r = '{27'sd6744441, -27'sd8355054, 27'sd1644167, -27'sd16777,
                            27'sd0};
      WIN_NUTTALL:    r = '{27'sd6099892, -27'sd8207037, 27'sd2291759, -27'sd178528,
                            27'sd0};
      default:        r = '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0};
    endcase
    return r;
  endfunction

endpackage

// ===== sv/wca_ram.sv =====
// Generic single-port-write, registered-read RAM.
module wca_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/wca_mul.sv =====
// Shared signed multiplier with a registered product.
module wca_mul #(
  parameter int unsigned W = 33
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  logic signed [2*W-1:0] p_q;

  // One product per cycle, registered before any use.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== sv/window_coefficient_apply.sv =====
// Top level of the window weighting block: sequencer, registers and datapath.
//
//  channel   direction  fields
//  s_axis    in         tdata: sample_in
//  m_axis    out        tdata: weighted_sample, tuser: frame_end
//  cfg       in         window_type, frame_length, recip_span, recip_len
//
// One sample steps through four table terms for cosine-sum windows and through fewer
// steps for the other windows, all on the single shared multiplier.
// After reset the cosine table is filled, one entry a cycle, until all entries are in;
// no sample is accepted meanwhile, configuration writes are taken as ever.
// A finished result waits in the output register while the next sample is taken in.
module window_coefficient_apply #(
  parameter int unsigned SAMPLE_BITS      = 24,
  parameter int unsigned MAX_FRAME        = 4096,
  parameter int unsigned COS_TABLE_DEPTH  = 1024,
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: [SAMPLE_BITS-1:0] sample_in, zero padded to bytes
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: [SAMPLE_BITS-1:0] weighted_sample, zero padded to bytes
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,
  // tuser: [0] frame_end
  output logic                                m_axis_tuser,
  input  logic                                cfg_we_i,
  input  logic [wca_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [wca_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  `include "window_coefficient_apply_macros.svh"

  localparam int unsigned DW     = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned PW     = $clog2(MAX_FRAME);
  localparam int unsigned LW     = $clog2(MAX_FRAME + 1);
  localparam int unsigned AW     = $clog2(COS_TABLE_DEPTH);
  localparam int unsigned JW     = $clog2(COS_TABLE_DEPTH + 1);
  localparam int unsigned XW     = PW + 32;
  localparam int unsigned WW     = WEIGHT_FRAC_BITS + 4;
  localparam int unsigned MW     = wca_pkg::MUL_W;
  localparam int unsigned PRW    = 2 * wca_pkg::MUL_W;
  localparam int unsigned AccW   = wca_pkg::ACC_W;
  localparam int unsigned SH_COS = 41 - WEIGHT_FRAC_BITS;
  localparam int unsigned SH_LIN = 32 - WEIGHT_FRAC_BITS;

  localparam logic [63:0] X_ONE = 64'h1_0000_0000;
  localparam logic signed [AccW-1:0] ACC_HALF_ONE = AccW'(64'sd8388608 <<< 17);
  localparam logic signed [AccW-1:0] ACC_BH0      = AccW'(64'sd10401874 <<< 17);
  localparam logic signed [AccW-1:0] HALF_COS     = AccW'(64'sd1 <<< (SH_COS - 1));
  localparam logic signed [AccW-1:0] HALF_LIN     = AccW'(64'sd1 <<< (SH_LIN - 1));
  localparam logic signed [AccW-1:0] W_MAX        = AccW'((64'sd1 <<< (WW - 1)) - 1);
  localparam logic signed [AccW-1:0] W_MIN        = -W_MAX - AccW'(1);
  localparam logic signed [PRW-1:0]  HALF_FIN     =
    PRW'(64'sd1 <<< (WEIGHT_FRAC_BITS - 1));
  localparam logic signed [PRW-1:0]  S_MAX        = PRW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [PRW-1:0]  S_MIN        = -S_MAX - PRW'(1);
  localparam longint TAYLOR_DIV [8] = '{1, 2, 12, 30, 56, 90, 132, 182};

  typedef logic [wca_pkg::COS_W-1:0] cos_rom_t [COS_TABLE_DEPTH];

  // Quarter-wave cosine in Q17, by a Q30 Taylor series up to the fourteenth power.
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    longint   theta;
    longint   t2;
    longint   acc;
    longint   p;
    for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
      theta = (64'sd1686629713 * longint'(k)) / COS_TABLE_DEPTH;
      t2    = (theta * theta) >>> 30;
      acc   = 64'sd1073741824;
      for (int n = 7; n >= 1; n--) begin
        p   = (t2 * acc) >>> 30;
        acc = 64'sd1073741824 - p / TAYLOR_DIV[n];
        if (acc < 0) begin
          acc = 0;
        end
      end
      rom[k] = wca_pkg::COS_W'((acc + 4096) >>> 13);
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_XMUL = 14'b00000000000010,
    ST_XCAP = 14'b00000000000100,
    ST_PRE  = 14'b00000000001000,
    ST_PREC = 14'b00000000010000,
    ST_USQ  = 14'b00000000100000,
    ST_UCAP = 14'b00000001000000,
    ST_TPH  = 14'b00000010000000,
    ST_TRD  = 14'b00000100000000,
    ST_TMUL = 14'b00001000000000,
    ST_TACC = 14'b00010000000000,
    ST_RND  = 14'b00100000000000,
    ST_FMUL = 14'b01000000000000,
    ST_FIN  = 14'b10000000000000
  } state_e;

  // Configuration and sequencer registers.
  logic [wca_pkg::WTYPE_W-1:0] wtype_q;
  logic [wca_pkg::FLEN_W-1:0]  flen_q;
  logic [31:0]                 rspan_q, rlen_q;
  state_e                      state_q, state_d;
  logic [PW-1:0]               pos_q, pos_d;
  logic [AW-1:0]               fill_cnt_q;
  logic                        fill_done_q;
  logic [2:0]                  term_q, term_d;

  // Datapath registers.
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [XW-1:0]                 xf_q, xf_d;
  logic signed [AccW-1:0]        acc_q, acc_d;
  logic [31:0]                   ph1_q, ph1_d;
  logic [AW-1:0]                 cidx_q, cidx_d;
  logic                          cneg_q, cneg_d, czero_q, czero_d;
  logic signed [WW-1:0]          w_q, w_d;
  logic                          out_valid_q;
  logic [DW-1:0]                 out_data_q;
  logic                          out_last_q;

  // Combinational helpers.
  wca_pkg::win_class_e     cls;
  wca_pkg::coef_row_t      row;
  logic [LW-1:0]           lenc, hl, d1;
  logic [32:0]             xc, dh, k;
  logic [16:0]             k16, u16;
  logic [33:0]             bart_v;
  logic [31:0]             x32, ph;
  logic [30+JW-1:0]        jprod;
  logic [JW-1:0]           j, idx;
  logic [wca_pkg::COS_W-1:0] ram_rdata;
  logic signed [wca_pkg::COS_W:0] cs;
  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [PRW-1:0]   p_mul;
  logic signed [AccW-1:0]  rsum_c, rsum_l, rw;
  logic signed [PRW-1:0]   fsum, fr;
  logic [SAMPLE_BITS-1:0]  fres;
  logic                    last, fin_go, last_term, in_xfer;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && fill_done_q;
  assign fin_go        = !out_valid_q || m_axis_tready;
  assign cls           = wca_pkg::win_class(wtype_q);
  assign row           = wca_pkg::coef_row(wtype_q);
  assign last_term     = (cls == wca_pkg::CLS_COSSUM) ? (term_q == 3'd4) : 1'b1;

  // Shared multiplier and cosine table.
  wca_mul #(.W(MW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p_mul)
  );

  wca_ram #(.WIDTH(wca_pkg::COS_W), .DEPTH(COS_TABLE_DEPTH)) u_cos_ram (
    .clk_i   (clk_i),
    .we_i    (!fill_done_q),
    .waddr_i (fill_cnt_q),
    .wdata_i (COS_ROM[fill_cnt_q]),
    .raddr_i (cidx_q),
    .rdata_o (ram_rdata)
  );

  // Frame geometry and position fraction terms.
  always_comb begin
    if (flen_q < wca_pkg::FLEN_W'(2)) begin
      lenc = LW'(2);
    end else if (32'(flen_q) > 32'(MAX_FRAME)) begin
      lenc = LW'(MAX_FRAME);
    end else begin
      lenc = LW'(flen_q);
    end
    hl     = lenc >> 1;
    d1     = (LW'(pos_q) >= hl) ? LW'(pos_q) - hl : hl - LW'(pos_q);
    last   = (LW'(pos_q) + LW'(1)) >= lenc;
    x32    = xf_q[31:0];
    xc     = (xf_q > XW'(X_ONE)) ? 33'h1_0000_0000 : xf_q[32:0];
    dh     = (xc >= 33'h0_8000_0000) ? xc - 33'h0_8000_0000 : 33'h0_8000_0000 - xc;
    k      = ({xc, 1'b0} >= 34'h1_0000_0000) ? 33'({xc, 1'b0} - 34'h1_0000_0000)
                                             : 33'(34'h1_0000_0000 - {xc, 1'b0});
    k16    = 17'((34'(k) + 34'd32768) >> 16);
    u16    = 17'((35'(acc_q[33:0]) + 35'd32768) >> 16);
    bart_v = ((LW + 1)'({pos_q, 1'b0}) <= (LW + 1)'(lenc - LW'(1)))
             ? {xc, 1'b0} : 34'h2_0000_0000 - {xc, 1'b0};
  end

  // Cosine table address from the phase of the current term.
  always_comb begin
    case (cls)
      wca_pkg::CLS_HANN_AC: ph = ph1_q;
      wca_pkg::CLS_BHANN:   ph = x32;
      default: begin
        case (term_q)
          3'd1:    ph = x32;
          3'd2:    ph = x32 << 1;
          3'd3:    ph = x32 + (x32 << 1);
          default: ph = x32 << 2;
        endcase
      end
    endcase
    jprod   = (30 + JW)'(ph[29:0]) * (30 + JW)'(COS_TABLE_DEPTH) + (30 + JW)'(1 << 29);
    j       = jprod[30+JW-1:30];
    idx     = ph[30] ? JW'(COS_TABLE_DEPTH) - j : j;
    cidx_d  = idx[AW-1:0];
    czero_d = (idx == JW'(COS_TABLE_DEPTH));
    cneg_d  = ph[31] ^ ph[30];
    cs      = czero_q ? '0 : (cneg_q ? -$signed({1'b0, ram_rdata})
                                     : $signed({1'b0, ram_rdata}));
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_XMUL: begin
        mul_a = MW'(pos_q);
        mul_b = MW'(rspan_q);
      end
      ST_PRE: begin
        case (cls)
          wca_pkg::CLS_HANN_AC: begin
            mul_a = MW'(d1);
            mul_b = MW'(rlen_q);
          end
          wca_pkg::CLS_BHANN: begin
            mul_a = MW'(23'd8053064);
            mul_b = MW'(dh);
          end
          default: begin
            mul_a = MW'(k16);
            mul_b = MW'(k16);
          end
        endcase
      end
      ST_USQ: begin
        mul_a = MW'(u16);
        mul_b = MW'(u16);
      end
      ST_TMUL: begin
        mul_a = MW'(row[term_q]);
        mul_b = MW'(cs);
      end
      ST_FMUL, ST_FIN: begin
        mul_a = MW'(sample_q);
        mul_b = MW'(w_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Weight rounding and saturation; result rounding and saturation.
  always_comb begin
    rsum_c = acc_q + HALF_COS - (acc_q[AccW-1] ? AccW'(1) : AccW'(0));
    rsum_l = acc_q + HALF_LIN - (acc_q[AccW-1] ? AccW'(1) : AccW'(0));
    if (cls == wca_pkg::CLS_COSSUM || cls == wca_pkg::CLS_HANN_AC ||
        cls == wca_pkg::CLS_BHANN) begin
      rw = rsum_c >>> SH_COS;
    end else begin
      rw = rsum_l >>> SH_LIN;
    end
    if (rw > W_MAX) begin
      w_d = WW'(W_MAX);
    end else if (rw < W_MIN) begin
      w_d = WW'(W_MIN);
    end else begin
      w_d = WW'(rw);
    end
    fsum = p_mul + HALF_FIN - (p_mul[PRW-1] ? PRW'(1) : PRW'(0));
    fr   = fsum >>> WEIGHT_FRAC_BITS;
    if (fr > S_MAX) begin
      fres = SAMPLE_BITS'(S_MAX);
    end else if (fr < S_MIN) begin
      fres = SAMPLE_BITS'(S_MIN);
    end else begin
      fres = SAMPLE_BITS'(fr);
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    term_d  = term_q;
    acc_d   = acc_q;
    ph1_d   = ph1_q;
    xf_d    = xf_q;
    pos_d   = pos_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_XMUL;
        end
      end
      ST_XMUL: state_d = ST_XCAP;
      ST_XCAP: begin
        xf_d    = XW'(p_mul);
        state_d = ST_PRE;
      end
      ST_PRE:  state_d = ST_PREC;
      ST_PREC: begin
        term_d = 3'd1;
        case (cls)
          wca_pkg::CLS_COSSUM: begin
            acc_d   = AccW'(row[0]) <<< 17;
            state_d = ST_TPH;
          end
          wca_pkg::CLS_HANN_AC: begin
            ph1_d   = p_mul[32:1];
            acc_d   = ACC_HALF_ONE;
            state_d = ST_TPH;
          end
          wca_pkg::CLS_BHANN: begin
            acc_d   = ACC_BH0 - AccW'(p_mul[53:15]);
            state_d = ST_TPH;
          end
          wca_pkg::CLS_BART: begin
            acc_d   = AccW'(bart_v);
            state_d = ST_RND;
          end
          wca_pkg::CLS_CONNES: begin
            acc_d   = AccW'(34'h1_0000_0000 - p_mul[33:0]);
            state_d = ST_USQ;
          end
          wca_pkg::CLS_WELCH: begin
            acc_d   = AccW'(34'h1_0000_0000 - p_mul[33:0]);
            state_d = ST_RND;
          end
          default: begin
            acc_d   = AccW'(X_ONE);
            state_d = ST_RND;
          end
        endcase
      end
      ST_USQ:  state_d = ST_UCAP;
      ST_UCAP: begin
        acc_d   = AccW'(p_mul[33:0]);
        state_d = ST_RND;
      end
      ST_TPH:  state_d = ST_TRD;
      ST_TRD:  state_d = ST_TMUL;
      ST_TMUL: state_d = ST_TACC;
      ST_TACC: begin
        acc_d = acc_q + $signed(p_mul[AccW-1:0]);
        if (last_term) begin
          state_d = ST_RND;
        end else begin
          term_d  = term_q + 3'd1;
          state_d = ST_TPH;
        end
      end
      ST_RND:  state_d = ST_FMUL;
      ST_FMUL: state_d = ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          pos_d   = last ? '0 : pos_q + PW'(1);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      term_q      <= 3'd1;
      fill_cnt_q  <= '0;
      fill_done_q <= 1'b0;
      out_valid_q <= 1'b0;
      wtype_q     <= wca_pkg::WTYPE_W'(wca_pkg::WIN_HANN);
      flen_q      <= wca_pkg::FLEN_W'(1024);
      rspan_q     <= 32'd4198404;
      rlen_q      <= 32'd4194304;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      term_q  <= term_d;
      if (!fill_done_q) begin
        fill_cnt_q <= fill_cnt_q + AW'(1);
        if (fill_cnt_q == AW'(COS_TABLE_DEPTH - 1)) begin
          fill_done_q <= 1'b1;
        end
      end
      if (state_q == ST_FIN && fin_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (wca_pkg::cfg_reg_e'(cfg_idx_i))
          wca_pkg::REG_WINDOW_TYPE:  wtype_q <= cfg_data_i[wca_pkg::WTYPE_W-1:0];
          wca_pkg::REG_FRAME_LENGTH: flen_q  <= cfg_data_i[wca_pkg::FLEN_W-1:0];
          wca_pkg::REG_RECIP_SPAN:   rspan_q <= cfg_data_i;
          wca_pkg::REG_RECIP_LEN:    rlen_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    xf_q    <= xf_d;
    acc_q   <= acc_d;
    ph1_q   <= ph1_d;
    if (in_xfer) begin
      sample_q <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
    end
    if (state_q == ST_TPH) begin
      cidx_q  <= cidx_d;
      cneg_q  <= cneg_d;
      czero_q <= czero_d;
    end
    if (state_q == ST_RND) begin
      w_q <= w_d;
    end
    if (state_q == ST_FIN && fin_go) begin
      out_data_q <= DW'(fres);
      out_last_q <= last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_last_q;

  // Checks on the sequencer.
  `WCA_ASSERT_NEXT(a_one_item, in_xfer, !s_axis_tready, "sample taken while busy")
  `WCA_ASSERT_NEXT(a_frame_wrap, (state_q == ST_FIN) && fin_go && last, pos_q == '0,
                   "position did not wrap at frame end")
  `WCA_ASSERT_IMPL(a_term_range, state_q == ST_TMUL, (term_q >= 3'd1) && (term_q <= 3'd4),
                   "cosine term index out of range")
  `WCA_ASSERT_IMPL(a_fill_blocks, !fill_done_q, state_q == ST_IDLE,
                   "sample in work during table fill")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the window weighting block.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned SW = 24;
  localparam longint TURN = 64'd4294967296;
  localparam longint MASK32 = 64'hFFFFFFFF;

  typedef struct packed {
    logic [SW-1:0] product;
    logic          frame_end;
  } weighted_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    wca_pkg::cfg_reg_e reg_idx;
    logic [31:0]       value;
    logic [SW-1:0]     smp;
    bit                known;
    logic [SW-1:0]     known_product;
    bit                known_end;
  } stim_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  // tdata: [23:0] sample_in
  logic [SW-1:0] s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  // tdata: [23:0] weighted_sample
  logic [SW-1:0] m_axis_tdata;
  // tuser: [0] frame_end
  logic          m_axis_tuser;
  logic          cfg_we_i = 1'b0;
  logic [wca_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [wca_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  window_coefficient_apply dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Predictor state: register copies, frame position and the cosine quarter wave.
  logic [3:0]  win_type_q;
  logic [12:0] frame_len_q;
  logic [31:0] span_recip_q;
  logic [31:0] len_recip_q;
  longint      frame_pos;
  longint      quarter_cos [0:1023];
  longint      coef_q24 [0:11][0:4];

  weighted_t   pending_products [$];
  int          error_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_requests = 0;

  // Clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint round_shift(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v < 0) return -((-v + half) >> s);
    return (v + half) >> s;
  endfunction

  // Cosine of a Q0.32 turn, Q17.
  function automatic longint cos_of_turn(longint ph);
    longint quad, low, j;
    quad = (ph >> 30) & 3;
    low = ph & 64'h3FFFFFFF;
    j = (low * 1024 + (longint'(1) << 29)) >> 30;
    case (quad)
      0: return (j < 1024) ? quarter_cos[j] : 0;
      1: return (1024 - j < 1024) ? -quarter_cos[1024 - j] : 0;
      2: return (j < 1024) ? -quarter_cos[j] : 0;
      default: return (1024 - j < 1024) ? quarter_cos[1024 - j] : 0;
    endcase
  endfunction

  // Q4.16 weight of position i in a frame of len samples.
  function automatic longint window_weight(longint i, longint len);
    longint xf, x32, xc, w, acc, d, ph, k, k16, u, u16, hl;
    xf = i * longint'(span_recip_q);
    x32 = xf & MASK32;
    xc = (xf > TURN) ? TURN : xf;
    case (win_type_q)
      wca_pkg::WIN_HANN, wca_pkg::WIN_HAMMING, wca_pkg::WIN_BLACKMAN,
      wca_pkg::WIN_BLACK_HARR, wca_pkg::WIN_FLATTOP,
      wca_pkg::WIN_KB_APPROX, wca_pkg::WIN_NUTTALL: begin
        acc = coef_q24[win_type_q][0] * 131072;
        for (int m = 1; m < 5; m++)
          acc += coef_q24[win_type_q][m] * cos_of_turn((m * x32) & MASK32);
        w = round_shift(acc, 25);
      end
      wca_pkg::WIN_HANN_AC: begin
        hl = len / 2;
        d = (i >= hl) ? i - hl : hl - i;
        ph = ((d * longint'(len_recip_q)) >> 1) & MASK32;
        acc = 8388608 * 131072 + 8388608 * cos_of_turn(ph);
        w = round_shift(acc, 25);
      end
      wca_pkg::WIN_BARTLETT: begin
        w = round_shift((2 * i <= len - 1) ? 2 * xc : 2 * TURN - 2 * xc, 16);
      end
      wca_pkg::WIN_BART_HANN: begin
        d = (xc >= TURN / 2) ? xc - TURN / 2 : TURN / 2 - xc;
        acc = 64'd10401874 * 131072 - ((64'd8053064 * d) >> 15)
              - 64'd6375342 * cos_of_turn(x32);
        w = round_shift(acc, 25);
      end
      wca_pkg::WIN_CONNES, wca_pkg::WIN_WELCH: begin
        k = (2 * xc >= TURN) ? 2 * xc - TURN : TURN - 2 * xc;
        k16 = (k + 32768) >> 16;
        u = TURN - k16 * k16;
        if (win_type_q == wca_pkg::WIN_CONNES) begin
          u16 = (u + 32768) >> 16;
          u = u16 * u16;
        end
        w = round_shift(u, 16);
      end
      default: w = 64'd65536;
    endcase
    if (w > (8 << 16) - 1) w = (8 << 16) - 1;
    if (w < -(8 << 16)) w = -(8 << 16);
    return w;
  endfunction

  // Weight one sample and advance the frame position.
  function automatic weighted_t weigh_sample(logic [SW-1:0] smp);
    weighted_t r;
    longint s, len, p;
    s = $signed(smp);
    len = frame_len_q;
    if (len < 2) len = 2;
    if (len > 4096) len = 4096;
    p = round_shift(s * window_weight(frame_pos, len), 16);
    if (p > 8388607) p = 8388607;
    if (p < -8388608) p = -8388608;
    r.product = p[SW-1:0];
    r.frame_end = (frame_pos + 1 >= len);
    frame_pos = r.frame_end ? 0 : frame_pos + 1;
    return r;
  endfunction

  task automatic report(string what, logic [SW-1:0] got, logic [SW-1:0] want);
    if (error_count < 20)
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Result side: check each transfer, then choose tready for the next edge.
  int hold_left = 0;
  int holds_done = 0;
  always @(posedge clk_i) begin
    weighted_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_products.size() == 0) begin
        report("unexpected result", m_axis_tdata, '0);
      end else begin
        want = pending_products.pop_front();
        if (m_axis_tdata !== want.product)
          report("weighted_sample", m_axis_tdata, want.product);
        if (m_axis_tuser !== want.frame_end)
          report("frame_end", SW'(m_axis_tuser), SW'(want.frame_end));
      end
    end
    if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = 400;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one sample and hold it until the transfer; then maybe go idle.
  task automatic send_sample(logic [SW-1:0] smp, bit known, logic [SW-1:0] kp, bit ke);
    weighted_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = weigh_sample(smp);
    if (known) begin
      pred.product = kp;
      pred.frame_end = ke;
    end
    pending_products.push_back(pred);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
      @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk_i);
  endtask

  // Write one register; the caller lowers the write enable after the batch.
  task automatic write_reg(wca_pkg::cfg_reg_e idx, logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      wca_pkg::REG_WINDOW_TYPE:  win_type_q = value[3:0];
      wca_pkg::REG_FRAME_LENGTH: frame_len_q = value[12:0];
      wca_pkg::REG_RECIP_SPAN:   span_recip_q = value;
      default:                   len_recip_q = value;
    endcase
  endtask

  function automatic logic [SW-1:0] random_sample();
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return SW'($urandom());
    endcase
  endfunction

  stim_row_t directed [$];

  function automatic stim_row_t cfg_row(wca_pkg::cfg_reg_e idx, logic [31:0] value);
    stim_row_t r;
    r.kind = ROW_CFG; r.reg_idx = idx; r.value = value;
    r.smp = '0; r.known = 0; r.known_product = '0; r.known_end = 0;
    return r;
  endfunction

  function automatic stim_row_t smp_row(logic [SW-1:0] smp, bit known = 0,
                                        logic [SW-1:0] kp = '0, bit ke = 0);
    stim_row_t r;
    r.kind = ROW_SAMPLE; r.reg_idx = wca_pkg::REG_WINDOW_TYPE; r.value = '0;
    r.smp = smp; r.known = known; r.known_product = kp; r.known_end = ke;
    return r;
  endfunction

  initial begin
    longint theta, t2, acc, p, len, span;
    int n_items;

    // Quarter-wave cosine by the same integer Taylor series the block uses.
    for (int k = 0; k < 1024; k++) begin
      theta = (64'd1686629713 * k) / 1024;
      t2 = (theta * theta) >> 30;
      acc = 64'd1073741824;
      for (int n = 7; n >= 1; n--) begin
        p = (t2 * acc) >> 30;
        acc = 64'd1073741824 - p / ((2 * n - 1) * (2 * n));
        if (acc < 0) acc = 0;
      end
      quarter_cos[k] = (acc + 4096) >> 13;
    end
    coef_q24 = '{
      '{8388608, -8388608, 0, 0, 0},
      '{0, 0, 0, 0, 0},
      '{9059697, -7717519, 0, 0, 0},
      '{7046431, -8388608, 1342177, 0, 0},
      '{6018826, -8192147, 2370285, -195958, 0},
      '{0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0},
      '{16777216, -32380027, 21642609, -6509560, 540226},
      '{6744441, -8355054, 1644167, -16777, 0},
      '{6099892, -8207037, 2291759, -178528, 0},
      '{0, 0, 0, 0, 0}};
    win_type_q = wca_pkg::WIN_HANN;
    frame_len_q = 13'd1024;
    span_recip_q = 32'd4198404;
    len_recip_q = 32'd4194304;
    frame_pos = 0;

    // Directed rows: unity types pass samples unchanged, then cosine windows,
    // a frame shortened in mid frame, clamped lengths and an oversized span.
    directed = '{
      cfg_row(wca_pkg::REG_WINDOW_TYPE, 32'd12), cfg_row(wca_pkg::REG_FRAME_LENGTH, 32'd4),
      cfg_row(wca_pkg::REG_RECIP_SPAN, 32'd1431655765),
      cfg_row(wca_pkg::REG_RECIP_LEN, 32'd1073741824),
      smp_row(24'h7FFFFF, 1, 24'h7FFFFF, 0), smp_row(24'h800000, 1, 24'h800000, 0),
      smp_row(24'h000000, 1, 24'h000000, 0), smp_row(24'hFFFFFF, 1, 24'hFFFFFF, 1),
      cfg_row(wca_pkg::REG_WINDOW_TYPE, 32'd15), smp_row(24'h123456, 1, 24'h123456, 0),
      cfg_row(wca_pkg::REG_WINDOW_TYPE, wca_pkg::WIN_HANN), smp_row(24'h7FFFFF),
      smp_row(24'h800000), smp_row(24'h400000),
      cfg_row(wca_pkg::REG_WINDOW_TYPE, wca_pkg::WIN_FLATTOP),
      cfg_row(wca_pkg::REG_FRAME_LENGTH, 32'd8),
      cfg_row(wca_pkg::REG_RECIP_SPAN, 32'd613566757),
      cfg_row(wca_pkg::REG_RECIP_LEN, 32'd536870912),
      smp_row(24'h7FFFFF), smp_row(24'h7FFFFF), smp_row(24'h800000),
      smp_row(24'h7FFFFF), smp_row(24'h800000),
      cfg_row(wca_pkg::REG_FRAME_LENGTH, 32'd3), smp_row(24'h800000),
      cfg_row(wca_pkg::REG_FRAME_LENGTH, 32'd0),
      cfg_row(wca_pkg::REG_WINDOW_TYPE, wca_pkg::WIN_BARTLETT),
      cfg_row(wca_pkg::REG_RECIP_SPAN, 32'hFFFFFFFF), smp_row(24'h7FFFFF),
      smp_row(24'h800000),
      cfg_row(wca_pkg::REG_FRAME_LENGTH, 32'd8191),
      cfg_row(wca_pkg::REG_WINDOW_TYPE, wca_pkg::WIN_WELCH),
      smp_row(24'h7FFFFF), smp_row(24'h555555)};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[r]) begin
      if (directed[r].kind == ROW_CFG) begin
        if (r == 0 || directed[r - 1].kind != ROW_CFG) drain();
        write_reg(directed[r].reg_idx, directed[r].value);
        if (r + 1 < directed.size() && directed[r + 1].kind != ROW_CFG)
          cfg_we_i <= 1'b0;
      end else begin
        send_sample(directed[r].smp, directed[r].known,
                    directed[r].known_product, directed[r].known_end);
      end
    end

    // Random phases: every window type, mostly short frames, varied idling.
    for (int ph = 0; ph < 24; ph++) begin
      drain();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      if (ph == 6) len = 4096;
      else if ($urandom_range(7) == 0)
        len = $urandom_range(1) ? $urandom_range(1) : $urandom_range(8191, 4097);
      else len = $urandom_range(48, 2);
      span = (len > 1) ? (TURN + (len - 1) / 2) / (len - 1) : MASK32;
      write_reg(wca_pkg::REG_WINDOW_TYPE, ph % 16);
      write_reg(wca_pkg::REG_FRAME_LENGTH, len[31:0]);
      write_reg(wca_pkg::REG_RECIP_SPAN, ($urandom_range(5) == 0) ? $urandom() : span[31:0]);
      write_reg(wca_pkg::REG_RECIP_LEN, ($urandom_range(5) == 0) ? $urandom()
                : 32'((TURN + (len > 0 ? len : 1) / 2) / (len > 0 ? len : 1)));
      cfg_we_i <= 1'b0;
      // A long receiver hold-off while samples keep coming.
      if (ph == 3) hold_requests++;
      n_items = $urandom_range(55, 35);
      for (int it = 0; it < n_items; it++)
        send_sample(random_sample(), 0, '0, 0);
    end

    drain();
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
